>>> hdl/mcma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average package
// Control word layout, step numbers and the sequencer program.
// ----------------------------------------------------------------------------
package mcma_pkg;

  localparam int NUM_CHANNELS = 9;
  localparam logic [6:0] WINDOW_RESET = 7'd10;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_READ  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PREP  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIV   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_OUT   = 3'd5;

  // Jump conditions. When the condition is false the sequencer holds its step.
  typedef enum logic [2:0] {
    COND_ALWAYS     = 3'd0,
    COND_IN_ACCEPT  = 3'd1,
    COND_COUNT_LAST = 3'd2,
    COND_BIT_LAST   = 3'd3,
    COND_OUT_FREE   = 3'd4
  } cond_t;

  typedef struct packed {
    logic              in_load;   // store the record and set up the window
    logic              rd_issue;  // read one stored record, step back
    logic              div_load;  // load the dividers from the sums
    logic              div_step;  // one quotient bit in every lane
    logic              out_load;  // move the quotients to the output register
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t program_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{in_load: 1'b0, rd_issue: 1'b0, div_load: 1'b0, div_step: 1'b0,
           out_load: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        cw.in_load = 1'b1;
        cw.cond    = COND_IN_ACCEPT;
        cw.target  = STEP_READ;
      end
      STEP_READ: begin
        cw.rd_issue = 1'b1;
        cw.cond     = COND_COUNT_LAST;
        cw.target   = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        cw.target = STEP_PREP;
      end
      STEP_PREP: begin
        cw.div_load = 1'b1;
        cw.target   = STEP_DIV;
      end
      STEP_DIV: begin
        cw.div_step = 1'b1;
        cw.cond     = COND_BIT_LAST;
        cw.target   = STEP_OUT;
      end
      STEP_OUT: begin
        cw.out_load = 1'b1;
        cw.cond     = COND_OUT_FREE;
        cw.target   = STEP_IDLE;
      end
      default: begin
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> hdl/multichannel_moving_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel moving average
// Windowed mean of nine sensor channels over a ring store of records.
// ----------------------------------------------------------------------------
// Usage: one input beat carries a sensor record of nine signed channels. The
// record is written into a ring store of STORE_DEPTH entries, and the block
// returns one output beat with the mean of the newest n records per channel,
// where n is the smaller of the fill count and window_length clamped to
// 1..STORE_DEPTH. Means are truncated toward zero.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. window_length is written through cfg_write_enable and
// cfg_write_data; the user writes it only while the block is idle, which the block does not enforce.
// Timing: the time per record is set by the single read port of the store,
// which delivers one record per cycle, and by the restoring dividers, which
// make one quotient bit per cycle in nine parallel lanes. in_stall is high
// outside the idle step, so a new record is taken only after the previous
// one has gone through the read, drain, prep, divide and output steps.
// Reset clears the fill count, the write pointer and the sequencer, and sets
// the window to 10; store contents are simply never read until rewritten.
// When the receiver stalls, the result holds in the output register and the
// block still takes the next record; it then waits at its last step until
// the output register frees up.
// ----------------------------------------------------------------------------
module multichannel_moving_average_top #(
  parameter int STORE_DEPTH  = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           cfg_write_enable,
  input  logic [6:0]                     cfg_write_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z,
  input  logic signed [SAMPLE_WIDTH-1:0] temperature,
  input  logic signed [SAMPLE_WIDTH-1:0] sound_rms,
  input  logic signed [SAMPLE_WIDTH-1:0] sound_peak,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_x,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_y,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_z,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_x,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_y,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_z,
  output logic signed [SAMPLE_WIDTH-1:0] mean_temperature,
  output logic signed [SAMPLE_WIDTH-1:0] mean_sound_rms,
  output logic signed [SAMPLE_WIDTH-1:0] mean_sound_peak
);

  localparam int NCH   = mcma_pkg::NUM_CHANNELS;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int REC_W = NCH * SW;
  localparam int AW    = $clog2(STORE_DEPTH);
  // Wide enough to hold STORE_DEPTH itself.
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  // A sum of up to STORE_DEPTH samples.
  localparam int SUM_W = SW + CNT_W;
  // Width used for comparing the 7-bit window against the depth.
  localparam int WCW   = (CNT_W > 7) ? CNT_W : 7;
  localparam int BIT_W = $clog2(SW + 1);

  localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
  localparam logic [WCW-1:0]   DEPTH_WCW = WCW'(STORE_DEPTH);

  // Sequencer.
  logic [mcma_pkg::STEP_W-1:0] step;
  mcma_pkg::ctrl_word_t        cw;
  logic                        cond_true;

  // Configuration and ring bookkeeping.
  logic [6:0]       window_length;
  logic [AW-1:0]    write_pointer;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;
  logic [WCW-1:0]   win_clamped;
  logic [CNT_W-1:0] n_next;

  // Window walk.
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    rd_ptr;
  logic             rd_vld;

  // Store.
  logic [REC_W-1:0] store [STORE_DEPTH];
  logic [REC_W-1:0] in_rec;
  logic [REC_W-1:0] rd_data;

  // Datapath lanes.
  logic signed [SUM_W-1:0] sum [NCH];
  logic        [SUM_W-1:0] mag [NCH];
  logic        [CNT_W-1:0] rem [NCH];
  logic        [SW-1:0]    quo [NCH];
  logic                    neg [NCH];
  logic        [SW-1:0]    mean [NCH];
  logic        [BIT_W-1:0] bit_count;

  logic in_accept;
  logic out_free;

  assign in_stall  = (step != mcma_pkg::STEP_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign in_rec = {sound_peak, sound_rms, temperature, gyro_z, gyro_y, gyro_x,
                   accel_z, accel_y, accel_x};

  // Fetch the control word and evaluate the jump condition.
  always_comb begin
    cw = mcma_pkg::program_rom(step);
    unique case (cw.cond)
      mcma_pkg::COND_ALWAYS:     cond_true = 1'b1;
      mcma_pkg::COND_IN_ACCEPT:  cond_true = in_accept;
      mcma_pkg::COND_COUNT_LAST: cond_true = (count == CNT_W'(1));
      mcma_pkg::COND_BIT_LAST:   cond_true = (bit_count == BIT_W'(1));
      mcma_pkg::COND_OUT_FREE:   cond_true = out_free;
      default:                   cond_true = 1'b1;
    endcase
  end

  // Window size for the record being accepted: the new fill count against
  // the window clamped to one through the store depth.
  always_comb begin
    fill_next = (fill_count < DEPTH_CNT) ? fill_count + CNT_W'(1) : fill_count;
    if (window_length == 7'd0) begin
      win_clamped = WCW'(1);
    end else if (WCW'(window_length) > DEPTH_WCW) begin
      win_clamped = DEPTH_WCW;
    end else begin
      win_clamped = WCW'(window_length);
    end
    if (WCW'(fill_next) < win_clamped) begin
      n_next = fill_next;
    end else begin
      n_next = CNT_W'(win_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= mcma_pkg::STEP_IDLE;
      window_length <= mcma_pkg::WINDOW_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      rd_vld        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cond_true) begin
        step <= cw.target;
      end
      if (cfg_write_enable) begin
        window_length <= cfg_write_data;
      end
      if (cw.in_load && in_accept) begin
        write_pointer <= (write_pointer == LAST_ADDR) ? '0 : write_pointer + AW'(1);
        fill_count    <= fill_next;
      end
      rd_vld <= cw.rd_issue;
      if (cw.out_load && cond_true) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Ring store: one write port for the incoming record, one registered read
  // port that walks back from the newest record.
  always_ff @(posedge clk) begin
    if (cw.in_load && in_accept) begin
      store[write_pointer] <= in_rec;
    end
    if (cw.rd_issue) begin
      rd_data <= store[rd_ptr];
    end
  end

  // Walk control: the read pointer starts at the record just written.
  always_ff @(posedge clk) begin
    if (cw.in_load && in_accept) begin
      n      <= n_next;
      count  <= n_next;
      rd_ptr <= write_pointer;
    end else if (cw.rd_issue) begin
      count  <= count - CNT_W'(1);
      rd_ptr <= (rd_ptr == '0) ? LAST_ADDR : rd_ptr - AW'(1);
    end
    if (cw.div_load) begin
      bit_count <= BIT_W'(SW);
    end else if (cw.div_step) begin
      bit_count <= bit_count - BIT_W'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mag[c] = sum[c][SUM_W-1] ? SUM_W'(-sum[c]) : SUM_W'(sum[c]);
    end
  end

  // Per-channel lanes: accumulate, then restoring division by n. The mean
  // always fits the sample width, so the top bits of the magnitude are
  // already a partial remainder below n and only SW quotient bits are made.
  always_ff @(posedge clk) begin
    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] rem_sub;
    for (int c = 0; c < NCH; c++) begin
      if (cw.in_load && in_accept) begin
        sum[c] <= '0;
      end else if (rd_vld) begin
        sum[c] <= sum[c] + SUM_W'($signed(rd_data[c*SW +: SW]));
      end
      rem_sh  = {rem[c], quo[c][SW-1]};
      rem_sub = rem_sh - {1'b0, n};
      if (cw.div_load) begin
        neg[c] <= sum[c][SUM_W-1];
        rem[c] <= mag[c][SUM_W-1:SW];
        quo[c] <= mag[c][SW-1:0];
      end else if (cw.div_step) begin
        if (rem_sh >= {1'b0, n}) begin
          rem[c] <= rem_sub[CNT_W-1:0];
          quo[c] <= {quo[c][SW-2:0], 1'b1};
        end else begin
          rem[c] <= rem_sh[CNT_W-1:0];
          quo[c] <= {quo[c][SW-2:0], 1'b0};
        end
      end
      if (cw.out_load && cond_true) begin
        mean[c] <= neg[c] ? SW'(-quo[c]) : quo[c];
      end
    end
  end

  assign mean_accel_x     = $signed(mean[0]);
  assign mean_accel_y     = $signed(mean[1]);
  assign mean_accel_z     = $signed(mean[2]);
  assign mean_gyro_x      = $signed(mean[3]);
  assign mean_gyro_y      = $signed(mean[4]);
  assign mean_gyro_z      = $signed(mean[5]);
  assign mean_temperature = $signed(mean[6]);
  assign mean_sound_rms   = $signed(mean[7]);
  assign mean_sound_peak  = $signed(mean[8]);

endmodule
